/* src/scaled_integer_to_decimal_text_unit_defines.svh */
// Assertion macros used by the checker file of this block.
`ifndef SCALED_INTEGER_TO_DECIMAL_TEXT_UNIT_DEFINES_SVH
`define SCALED_INTEGER_TO_DECIMAL_TEXT_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle, outside reset.
`define SIDT_ASSERT_NOW(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("sidt: same-cycle check failed");

// The consequent must hold in the next cycle, outside reset.
`define SIDT_ASSERT_NEXT(name, clk, pre, post, rst) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("sidt: next-cycle check failed");

// The consequent must hold in the next cycle, also across reset.
`define SIDT_ASSERT_NEXT_ALWAYS(name, clk, pre, post) \
   name: assert property (@(posedge clk) (pre) |=> (post)) \
      else $error("sidt: next-cycle check across reset failed");

`endif

/* src/sidt_pkg.sv */
package sidt_pkg;

   localparam int MAG_W = 64;
   localparam int SCALE_W = 6;
   localparam int CHAR_W = 8;
   localparam int NUM_DIGITS = 19;
   localparam int BCD_W = NUM_DIGITS * 4;
   localparam int POS_W = 5;
   localparam int CONV_CNT_W = $clog2(MAG_W);
   localparam int DEFAULT_QUEUE_DEPTH = 2;

   localparam logic signed [SCALE_W-1:0] SCALE_MIN = -6'sd18;

   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CHAR_POINT = 8'h2E;
   localparam logic [CHAR_W-1:0] CHAR_STAR  = 8'h2A;

   typedef enum logic [1:0] {
      KIND_ZERO = 2'd0,
      KIND_STAR = 2'd1,
      KIND_NUM  = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type                   kind;
      logic                       neg;
      logic [MAG_W-1:0]           mag;
      logic signed [SCALE_W-1:0]  scale;
   } job_type;

endpackage

/* src/sidt_front.sv */
module sidt_front (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [sidt_pkg::MAG_W-1:0]      req_number_in,
   input  logic signed [sidt_pkg::SCALE_W-1:0]    req_frac_digits,
   output logic                                   job_valid,
   input  logic                                   job_stall,
   output sidt_pkg::job_type                      job
);

   logic              job_valid_ff, job_valid_in;
   sidt_pkg::job_type job_ff, job_in;
   logic              neg;

   assign req_stall = job_valid_ff && job_stall;
   assign job_valid = job_valid_ff;
   assign job       = job_ff;
   assign neg       = req_number_in[sidt_pkg::MAG_W-1];

   always_comb begin
      job_in       = job_ff;
      job_valid_in = job_valid_ff && job_stall;
      if (req_valid && !req_stall) begin
         job_valid_in = 1'b1;
         job_in.neg   = neg;
         job_in.scale = req_frac_digits;
         job_in.mag   = neg ? (sidt_pkg::MAG_W'(0) - $unsigned(req_number_in))
                            : $unsigned(req_number_in);
         if (req_number_in == '0) begin
            job_in.kind = sidt_pkg::KIND_ZERO;
         end else if (req_frac_digits < sidt_pkg::SCALE_MIN) begin
            job_in.kind = sidt_pkg::KIND_STAR;
         end else begin
            job_in.kind = sidt_pkg::KIND_NUM;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
      end else begin
         job_valid_ff <= job_valid_in;
      end
      job_ff <= job_in;
   end

endmodule

/* src/sidt_queue.sv */
module sidt_queue #(
   parameter int DEPTH = sidt_pkg::DEFAULT_QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_stall,
   input  sidt_pkg::job_type in_job,
   output logic              out_valid,
   input  logic              out_stall,
   output sidt_pkg::job_type out_job
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   sidt_pkg::job_type entries_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              push, pop;

   assign in_stall  = (count_ff == CNT_W'(DEPTH));
   assign out_valid = (count_ff != '0);
   assign push      = in_valid && !in_stall;
   assign pop       = out_valid && !out_stall;
   assign out_job   = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entries_ff[wr_ptr_ff] <= in_job;
      end
   end

endmodule

/* src/sidt_back.sv */
module sidt_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              job_valid,
   output logic                              job_stall,
   input  sidt_pkg::job_type                 job,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [sidt_pkg::CHAR_W-1:0]       rsp_text_char,
   output logic                              rsp_is_last
);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_CONV  = 6'b000010,
      ST_SIZE  = 6'b000100,
      ST_SIGN  = 6'b001000,
      ST_DIGIT = 6'b010000,
      ST_FIXED = 6'b100000
   } state_type;

   state_type                               state_ff, state_in;
   logic                                    neg_ff, neg_in;
   logic signed [sidt_pkg::SCALE_W-1:0]     scale_ff, scale_in;
   logic [sidt_pkg::MAG_W-1:0]              bin_ff, bin_in;
   logic [sidt_pkg::BCD_W-1:0]              bcd_ff, bcd_in;
   logic [sidt_pkg::CONV_CNT_W-1:0]         cnt_ff, cnt_in;
   logic [sidt_pkg::POS_W-1:0]              pos_ff, pos_in;
   logic                                    point_ff, point_in;
   logic [sidt_pkg::CHAR_W-1:0]             fixed_char_ff, fixed_char_in;
   logic                                    rsp_valid_ff, rsp_valid_in;
   logic [sidt_pkg::CHAR_W-1:0]             rsp_text_char_ff, rsp_text_char_in;
   logic                                    rsp_is_last_ff, rsp_is_last_in;

   logic                                    out_free;
   logic [sidt_pkg::BCD_W-1:0]              bcd_adj;
   logic [sidt_pkg::POS_W-1:0]              ndig;
   logic [sidt_pkg::POS_W-1:0]              top;
   logic [sidt_pkg::POS_W-1:0]              point_pos;
   logic                                    pos_scale;
   logic [3:0]                              digit_sel;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_text_char = rsp_text_char_ff;
   assign rsp_is_last   = rsp_is_last_ff;
   assign job_stall     = (state_ff != ST_IDLE);
   assign out_free      = !rsp_valid_ff || !rsp_stall;
   assign pos_scale     = !scale_ff[sidt_pkg::SCALE_W-1] && (scale_ff != '0);
   assign point_pos     = scale_ff[sidt_pkg::POS_W-1:0] - 1'b1;

   always_comb begin
      for (int i = 0; i < sidt_pkg::NUM_DIGITS; i++) begin
         bcd_adj[i*4 +: 4] = (bcd_ff[i*4 +: 4] >= 4'd5) ? bcd_ff[i*4 +: 4] + 4'd3
                                                         : bcd_ff[i*4 +: 4];
      end
   end

   always_comb begin
      ndig      = '0;
      digit_sel = '0;
      for (int i = 0; i < sidt_pkg::NUM_DIGITS; i++) begin
         if (bcd_ff[i*4 +: 4] != 4'd0) begin
            ndig = sidt_pkg::POS_W'(i + 1);
         end
         if (pos_ff == sidt_pkg::POS_W'(i)) begin
            digit_sel = bcd_ff[i*4 +: 4];
         end
      end
      top = (pos_scale && (scale_ff[sidt_pkg::POS_W-1:0] > ndig))
            ? scale_ff[sidt_pkg::POS_W-1:0] : ndig;
   end

   always_comb begin
      state_in         = state_ff;
      neg_in           = neg_ff;
      scale_in         = scale_ff;
      bin_in           = bin_ff;
      bcd_in           = bcd_ff;
      cnt_in           = cnt_ff;
      pos_in           = pos_ff;
      point_in         = point_ff;
      fixed_char_in    = fixed_char_ff;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      rsp_text_char_in = rsp_text_char_ff;
      rsp_is_last_in   = rsp_is_last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               neg_in   = job.neg;
               scale_in = job.scale;
               bin_in   = job.mag;
               bcd_in   = '0;
               cnt_in   = '0;
               case (job.kind)
                  sidt_pkg::KIND_ZERO: begin
                     fixed_char_in = sidt_pkg::CHAR_ZERO;
                     state_in      = ST_FIXED;
                  end
                  sidt_pkg::KIND_STAR: begin
                     fixed_char_in = sidt_pkg::CHAR_STAR;
                     cnt_in        = sidt_pkg::CONV_CNT_W'(2);
                     state_in      = ST_FIXED;
                  end
                  default: begin
                     state_in = ST_CONV;
                  end
               endcase
            end
         end
         ST_CONV: begin
            bcd_in = {bcd_adj[sidt_pkg::BCD_W-2:0], bin_ff[sidt_pkg::MAG_W-1]};
            bin_in = {bin_ff[sidt_pkg::MAG_W-2:0], 1'b0};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == sidt_pkg::CONV_CNT_W'(sidt_pkg::MAG_W - 1)) begin
               state_in = ST_SIZE;
            end
         end
         ST_SIZE: begin
            pos_in   = top - 1'b1;
            point_in = pos_scale;
            state_in = neg_ff ? ST_SIGN : ST_DIGIT;
         end
         ST_SIGN: begin
            if (out_free) begin
               rsp_valid_in     = 1'b1;
               rsp_text_char_in = sidt_pkg::CHAR_MINUS;
               rsp_is_last_in   = 1'b0;
               state_in         = ST_DIGIT;
            end
         end
         ST_DIGIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (point_ff && (pos_ff == point_pos)) begin
                  rsp_text_char_in = sidt_pkg::CHAR_POINT;
                  rsp_is_last_in   = 1'b0;
                  point_in         = 1'b0;
               end else begin
                  rsp_text_char_in = sidt_pkg::CHAR_ZERO + {4'd0, digit_sel};
                  rsp_is_last_in   = (pos_ff == '0);
                  if (pos_ff == '0) begin
                     state_in = ST_IDLE;
                  end else begin
                     pos_in = pos_ff - 1'b1;
                  end
               end
            end
         end
         ST_FIXED: begin
            if (out_free) begin
               rsp_valid_in     = 1'b1;
               rsp_text_char_in = fixed_char_ff;
               rsp_is_last_in   = (cnt_ff == '0);
               if (cnt_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  cnt_in = cnt_ff - 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      neg_ff           <= neg_in;
      scale_ff         <= scale_in;
      bin_ff           <= bin_in;
      bcd_ff           <= bcd_in;
      cnt_ff           <= cnt_in;
      pos_ff           <= pos_in;
      point_ff         <= point_in;
      fixed_char_ff    <= fixed_char_in;
      rsp_text_char_ff <= rsp_text_char_in;
      rsp_is_last_ff   <= rsp_is_last_in;
   end

endmodule

/* src/scaled_integer_to_decimal_text_unit.sv */
// Formats a signed 64-bit integer with a scale (count of fractional digits)
// as decimal ASCII text, one character per beat, most significant first.
// The request channel carries req_number_in and req_frac_digits; the response
// channel carries rsp_text_char and rsp_is_last, which marks the final beat.
// A front stage classifies each request and hands it through a short queue
// to a back end that converts and emits, so requests keep flowing in while
// the back end is busy, until the queue fills.
// A nonzero number with a usable scale passes through a bit-serial
// double-dabble converter, then a step that sizes the digit string, and then
// its characters are emitted; the back end takes no new job until it has
// emitted the last character of the current one. Zero and out-of-range
// scales skip the converter and the sizing step.
// Reset is synchronous and empties the front stage, the queue, the back end
// and the response register. While the receiver stalls, the response beat
// holds and the back end waits; the queue then fills and stalls requests.
module scaled_integer_to_decimal_text_unit #(
   parameter int QUEUE_DEPTH = sidt_pkg::DEFAULT_QUEUE_DEPTH
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [sidt_pkg::MAG_W-1:0]    req_number_in,
   input  logic signed [sidt_pkg::SCALE_W-1:0]  req_frac_digits,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [sidt_pkg::CHAR_W-1:0]          rsp_text_char,
   output logic                                 rsp_is_last
);

   logic              front_valid, front_stall;
   sidt_pkg::job_type front_job;
   logic              back_valid, back_stall;
   sidt_pkg::job_type back_job;

   sidt_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_number_in   (req_number_in),
      .req_frac_digits (req_frac_digits),
      .job_valid       (front_valid),
      .job_stall       (front_stall),
      .job             (front_job)
   );

   sidt_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_stall  (front_stall),
      .in_job    (front_job),
      .out_valid (back_valid),
      .out_stall (back_stall),
      .out_job   (back_job)
   );

   sidt_back u_back (
      .clock         (clock),
      .reset         (reset),
      .job_valid     (back_valid),
      .job_stall     (back_stall),
      .job           (back_job),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_text_char (rsp_text_char),
      .rsp_is_last   (rsp_is_last)
   );

endmodule

/* src/sidt_checker.sv */
`include "scaled_integer_to_decimal_text_unit_defines.svh"

module sidt_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 rsp_valid,
   input logic                                 rsp_stall,
   input logic [sidt_pkg::CHAR_W-1:0]          rsp_text_char,
   input logic                                 rsp_is_last
);

   logic legal_char;
   logic minus_beat;

   assign legal_char = ((rsp_text_char >= sidt_pkg::CHAR_ZERO) &&
                        (rsp_text_char <= sidt_pkg::CHAR_ZERO + 8'd9)) ||
                       (rsp_text_char == sidt_pkg::CHAR_MINUS) ||
                       (rsp_text_char == sidt_pkg::CHAR_POINT) ||
                       (rsp_text_char == sidt_pkg::CHAR_STAR);
   assign minus_beat = rsp_valid && (rsp_text_char == sidt_pkg::CHAR_MINUS);

   `SIDT_ASSERT_NEXT(a_rsp_hold, clock, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_text_char) && $stable(rsp_is_last), reset)
   `SIDT_ASSERT_NEXT_ALWAYS(a_reset_clears, clock, reset, !rsp_valid)
   `SIDT_ASSERT_NOW(a_legal_char, clock, reset, rsp_valid, legal_char)
   `SIDT_ASSERT_NOW(a_minus_not_last, clock, reset, minus_beat, !rsp_is_last)
   `SIDT_ASSERT_NEXT(a_sign_leads, clock, minus_beat && !rsp_stall, !minus_beat, reset)

endmodule

bind scaled_integer_to_decimal_text_unit sidt_checker u_sidt_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_text_char   (rsp_text_char),
   .rsp_is_last     (rsp_is_last)
);
